FILE: src/assert_macros.svh
// Assertion macros for the RTL of the short-name converter.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define SN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent
`define SN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sn2de_pkg.sv
// Package for the 8.3 short-name converter: widths, character constants
// and the character classification functions. No dependencies.
`timescale 1ns / 1ps

package sn2de_pkg;

  localparam int unsigned NameLen   = 11;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned ByteW     = 8;

  localparam logic [IdxW-1:0]  BaseLen   = 4'd8;
  localparam logic [IdxW-1:0]  NameEnd   = 4'd11;
  localparam logic [IdxW-1:0]  LastIdx   = 4'd10;
  localparam logic [IdxW-1:0]  MaxChars  = 4'd12;
  localparam logic [IdxW-1:0]  CountSat  = 4'd13;

  localparam logic [ByteW-1:0] SpaceByte  = 8'h20;
  localparam logic [ByteW-1:0] PeriodByte = 8'h2E;
  localparam logic [ByteW-1:0] LowerA     = 8'h61;
  localparam logic [ByteW-1:0] LowerZ     = 8'h7A;
  localparam logic [ByteW-1:0] CaseOffset = 8'h20;

  typedef logic [ByteW-1:0] name_byte_t;

  // Punctuation that may not appear in a short name
  function automatic logic is_forbidden(input name_byte_t c);
    logic hit;
    hit = 1'b0;
    case (c)
      8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C,
      8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Fold a..z onto A..Z, everything else unchanged
  function automatic name_byte_t to_upper(input name_byte_t c);
    name_byte_t r;
    r = c;
    if (c >= LowerA && c <= LowerZ) begin
      r = c - CaseOffset;
    end
    return r;
  endfunction

endpackage

FILE: src/short_name_to_dir_entry_core.sv
// Top level of the 8.3 short-name converter: character checker, name
// buffer and the burst emitter. Depends on sn2de_pkg and assert_macros.svh.
//
//   channel   dir   tdata                                    tuser    tlast
//   s_axis    in    [7:0] char_in                            -        is_last
//   m_axis    out   [7:0] entry_byte, [11:8] byte_index      status   last_out
//
// One character is taken per cycle while s_axis_tready is high.
// A finished name is copied to the emit buffer and sent as eleven beats
// (one beat on error), one per cycle while m_axis_tready is high; the next name streams in meanwhile.
// s_axis stalls only when a second name ends before the first has left.
// The last character sets done_q; once the emitter is free the name loads into ebuf_q and ebusy_q.
// Reset (rst_ni low, async) clears the name buffer to spaces and all control;
// the emit buffer is not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module short_name_to_dir_entry_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] entry_byte, [11:8] byte_index, [15:12] zero
  output logic        m_axis_tuser,   // [0] status
  output logic        m_axis_tlast    // last_out
);

  localparam int unsigned NameLen = sn2de_pkg::NameLen;
  localparam int unsigned IdxW    = sn2de_pkg::IdxW;

  // Working state of the name being collected
  sn2de_pkg::name_byte_t nbuf_q [NameLen];
  sn2de_pkg::name_byte_t nbuf_d [NameLen];
  logic [IdxW-1:0] wpos_q, wpos_d;
  logic [IdxW-1:0] ccnt_q, ccnt_d;
  logic            seen_q, seen_d;
  logic            err_q, err_d;
  logic            done_q, done_d;

  // Emitter state
  sn2de_pkg::name_byte_t ebuf_q [NameLen];
  logic [IdxW-1:0] ecnt_q;
  logic            eerr_q;
  logic            ebusy_q;

  logic s_hs, m_hs, e_last, e_load;
  sn2de_pkg::name_byte_t c_in, e_byte;

  assign c_in          = s_axis_tdata;
  assign s_axis_tready = !done_q || e_load;
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign m_hs          = m_axis_tvalid && m_axis_tready;
  assign e_last        = eerr_q || (ecnt_q == sn2de_pkg::LastIdx);
  assign e_load        = done_q && (!ebusy_q || (m_hs && e_last));

  // Per-character checks and buffer update
  always_comb begin
    nbuf_d = nbuf_q;
    wpos_d = wpos_q;
    ccnt_d = ccnt_q;
    seen_d = seen_q;
    err_d  = err_q;
    done_d = done_q;
    // a name handed to the emitter frees the working state
    if (e_load) begin
      for (int k = 0; k < NameLen; k++) begin
        nbuf_d[k] = sn2de_pkg::SpaceByte;
      end
      wpos_d = '0;
      ccnt_d = '0;
      seen_d = 1'b0;
      err_d  = 1'b0;
      done_d = 1'b0;
    end
    // a new character builds on the cleared state when both coincide
    if (s_hs) begin
      if (!err_d) begin
        if (ccnt_d >= sn2de_pkg::MaxChars || c_in <= sn2de_pkg::SpaceByte ||
            sn2de_pkg::is_forbidden(c_in)) begin
          err_d = 1'b1;
        end else if (c_in == sn2de_pkg::PeriodByte) begin
          if (seen_d || ccnt_d > sn2de_pkg::BaseLen) begin
            err_d = 1'b1;
          end else begin
            seen_d = 1'b1;
            wpos_d = sn2de_pkg::BaseLen;
          end
        end else if ((!seen_d && wpos_d >= sn2de_pkg::BaseLen) ||
                     (seen_d && wpos_d >= sn2de_pkg::NameEnd)) begin
          err_d = 1'b1;
        end else begin
          nbuf_d[wpos_d] = sn2de_pkg::to_upper(c_in);
          wpos_d         = wpos_d + 1'b1;
        end
      end
      if (ccnt_d < sn2de_pkg::CountSat) begin
        ccnt_d = ccnt_d + 1'b1;
      end
      done_d = s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NameLen; k++) begin
        nbuf_q[k] <= sn2de_pkg::SpaceByte;
      end
      wpos_q <= '0;
      ccnt_q <= '0;
      seen_q <= 1'b0;
      err_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      nbuf_q <= nbuf_d;
      wpos_q <= wpos_d;
      ccnt_q <= ccnt_d;
      seen_q <= seen_d;
      err_q  <= err_d;
      done_q <= done_d;
    end
  end

  // Emitter control: load a finished name, step through the beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ebusy_q <= 1'b0;
      ecnt_q  <= '0;
      eerr_q  <= 1'b0;
    end else if (e_load) begin
      ebusy_q <= 1'b1;
      ecnt_q  <= '0;
      eerr_q  <= err_q;
    end else if (m_hs) begin
      if (e_last) begin
        ebusy_q <= 1'b0;
      end else begin
        ecnt_q <= ecnt_q + 1'b1;
      end
    end
  end

  // Emit buffer payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (e_load) begin
      ebuf_q <= nbuf_q;
    end
  end

  // Output beat
  always_comb begin
    e_byte = '0;
    for (int k = 0; k < NameLen; k++) begin
      if (ecnt_q == k[IdxW-1:0]) begin
        e_byte = ebuf_q[k];
      end
    end
  end

  assign m_axis_tvalid = ebusy_q;
  assign m_axis_tdata  = eerr_q ? 16'h0000 : {4'h0, ecnt_q, e_byte};
  assign m_axis_tuser  = eerr_q;
  assign m_axis_tlast  = e_last;

  // Checks
  `SN_ASSERT(a_err_single, !(m_axis_tvalid && m_axis_tuser) || m_axis_tlast, "error beat not last")
  `SN_ASSERT(a_idx_range, !m_axis_tvalid || (ecnt_q <= sn2de_pkg::LastIdx), "beat index beyond name")
  `SN_ASSERT_NEXT(a_load_start, done_q && !ebusy_q, ebusy_q && (ecnt_q == '0), "finished name not taken")
  `SN_ASSERT_NEXT(a_burst_end, m_hs && m_axis_tlast && !done_q, !m_axis_tvalid, "burst ran past last beat")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for short_name_to_dir_entry_core: drives file names
// one byte per transaction and checks the 8.3 entry beats against a predictor.
// Depends on sn2de_pkg for widths and character constants.
`timescale 1ns / 1ps

module testbench;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;
  localparam int   ItemGoal  = 380;
  localparam int   CycleLimit = 2000000;
  localparam int   DrainWait = 20;

  // One entry beat as the block sends it
  typedef struct packed {
    logic [7:0] entry_byte;
    logic [3:0] byte_index;
    logic       status;
    logic       last_out;
  } entry_beat_t;

  // One name byte to send; err_typed marks rows whose error beat is typed in
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       err_typed;
  } name_char_t;

  // Directed rows: extremes, case folding and several kinds of bad name
  localparam int DirRows = 20;
  localparam name_char_t DirTable [DirRows] = '{
    '{8'h2E, 1'b1, 1'b0},                         // lone period: all spaces
    '{8'h00, 1'b1, 1'b1},                         // zero byte
    '{8'hFF, 1'b1, 1'b0},                         // top byte kept as is
    '{8'h21, 1'b1, 1'b0},                         // lowest legal byte
    '{8'h61, 1'b0, 1'b0},                         // "az.b" folded to upper case
    '{8'h7A, 1'b0, 1'b0},
    '{8'h2E, 1'b0, 1'b0},
    '{8'h62, 1'b1, 1'b0},
    '{8'h20, 1'b1, 1'b1},                         // space
    '{8'h7C, 1'b1, 1'b1},                         // forbidden punctuation
    '{8'h2E, 1'b0, 1'b0},                         // second period
    '{8'h2E, 1'b1, 1'b1},
    '{8'h41, 1'b0, 1'b0},                         // trailing period: empty ext
    '{8'h2E, 1'b1, 1'b0},
    '{8'h41, 1'b0, 1'b0},                         // extension of four bytes
    '{8'h2E, 1'b0, 1'b0},
    '{8'h62, 1'b0, 1'b0},
    '{8'h63, 1'b0, 1'b0},
    '{8'h64, 1'b0, 1'b0},
    '{8'h65, 1'b1, 1'b1}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] char_in
  logic        s_axis_tlast;    // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;    // [7:0] entry_byte, [11:8] byte_index, [15:12] zero
  logic        m_axis_tuser;    // [0] status
  logic        m_axis_tlast;    // last_out

  short_name_to_dir_entry_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  name_char_t  name_stream[$];
  entry_beat_t entry_due[$];
  entry_beat_t fresh_beats[$];

  // Predictor state
  logic [7:0] entry_name [sn2de_pkg::NameLen];
  logic [3:0] put_pos;
  logic [3:0] chars_taken;
  logic       period_seen;
  logic       name_bad;

  int mismatches   = 0;
  int cycles       = 0;
  int chars_in     = 0;
  int beats_out    = 0;
  int names_valid  = 0;
  int names_bad    = 0;

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 30) begin
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    end
  endtask

  function automatic logic punct_banned(input logic [7:0] c);
    return c inside {8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C,
                     8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C};
  endfunction

  function automatic void clear_name();
    for (int k = 0; k < sn2de_pkg::NameLen; k++) entry_name[k] = sn2de_pkg::SpaceByte;
    put_pos     = '0;
    chars_taken = '0;
    period_seen = 1'b0;
    name_bad    = 1'b0;
  endfunction

  // Take one name byte; a final byte leaves its beats in fresh_beats
  function automatic void convert_char(input logic [7:0] c, input logic fin);
    logic [3:0]  pos;
    entry_beat_t b;
    pos = chars_taken;
    if (chars_taken < sn2de_pkg::CountSat) chars_taken++;
    if (!name_bad) begin
      if (pos >= sn2de_pkg::MaxChars || c <= sn2de_pkg::SpaceByte || punct_banned(c)) begin
        name_bad = 1'b1;
      end else if (c == sn2de_pkg::PeriodByte) begin
        if (period_seen || pos > sn2de_pkg::BaseLen) begin
          name_bad = 1'b1;
        end else begin
          period_seen = 1'b1;
          put_pos     = sn2de_pkg::BaseLen;
        end
      end else if ((!period_seen && put_pos >= sn2de_pkg::BaseLen) ||
                   (period_seen && put_pos >= sn2de_pkg::NameEnd)) begin
        name_bad = 1'b1;
      end else begin
        entry_name[put_pos] = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
        put_pos++;
      end
    end
    if (fin) begin
      if (name_bad) begin
        b = '{8'h00, 4'd0, StatusBad, 1'b1};
        fresh_beats.push_back(b);
        names_bad++;
      end else begin
        for (int k = 0; k < sn2de_pkg::NameLen; k++) begin
          b = '{entry_name[k], 4'(k), StatusOk, (k == sn2de_pkg::NameLen - 1)};
          fresh_beats.push_back(b);
        end
        names_valid++;
      end
      clear_name();
    end
  endfunction

  // Random legal name byte, biased towards lower-case letters
  function automatic logic [7:0] legal_char();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 40) return 8'(($urandom_range(0, 25)) + 8'h61);
    do c = 8'($urandom_range(8'h21, 8'hFF));
    while (punct_banned(c) || c == sn2de_pkg::PeriodByte);
    return c;
  endfunction

  function automatic void push_name(input logic [7:0] bytes[$]);
    name_char_t r;
    foreach (bytes[i]) begin
      r = '{bytes[i], (i == bytes.size() - 1), 1'b0};
      name_stream.push_back(r);
    end
  endfunction

  // Build one random name: mostly well formed, the rest broken or noise
  function automatic void random_name();
    logic [7:0] bytes[$];
    int kind;
    int nb;
    int ne;
    bit dot;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      nb  = $urandom_range(0, 8);
      dot = (nb == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      ne  = dot ? $urandom_range(0, 3) : 0;
      repeat (nb) bytes.push_back(legal_char());
      if (dot) bytes.push_back(sn2de_pkg::PeriodByte);
      repeat (ne) bytes.push_back(legal_char());
      // poison one byte of some names with any value at all
      if (kind >= 65) bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind < 82) begin
      // base too long, sometimes with a period after it
      repeat ($urandom_range(9, 14)) bytes.push_back(legal_char());
      if ($urandom_range(0, 1)) begin
        bytes.insert($urandom_range(8, bytes.size()), sn2de_pkg::PeriodByte);
      end
    end else if (kind < 88) begin
      repeat ($urandom_range(0, 8)) bytes.push_back(legal_char());
      bytes.push_back(sn2de_pkg::PeriodByte);
      repeat ($urandom_range(4, 6)) bytes.push_back(legal_char());
    end else if (kind < 93) begin
      repeat ($urandom_range(0, 4)) bytes.push_back(legal_char());
      bytes.push_back(sn2de_pkg::PeriodByte);
      repeat ($urandom_range(0, 2)) bytes.push_back(legal_char());
      bytes.push_back(sn2de_pkg::PeriodByte);
      repeat ($urandom_range(0, 2)) bytes.push_back(legal_char());
    end else begin
      repeat ($urandom_range(1, 16)) bytes.push_back(8'($urandom_range(0, 255)));
    end
    push_name(bytes);
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, entry_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Monitor: predict on each accepted byte, check each accepted beat
  always @(posedge clk_i) begin
    entry_beat_t want;
    entry_beat_t typed;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        fresh_beats.delete();
        convert_char(s_axis_tdata, s_axis_tlast);
        if (name_stream[chars_in].err_typed) begin
          typed = '{8'h00, 4'd0, StatusBad, 1'b1};
          fresh_beats.delete();
          fresh_beats.push_back(typed);
        end
        foreach (fresh_beats[i]) entry_due.push_back(fresh_beats[i]);
        chars_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        if (entry_due.size() == 0) begin
          flag_mismatch("unexpected beat", m_axis_tdata, 0);
        end else begin
          want = entry_due.pop_front();
          if (m_axis_tdata[7:0] != want.entry_byte)
            flag_mismatch("entry_byte", m_axis_tdata[7:0], want.entry_byte);
          if (m_axis_tdata[11:8] != want.byte_index)
            flag_mismatch("byte_index", m_axis_tdata[11:8], want.byte_index);
          if (m_axis_tuser != want.status)
            flag_mismatch("status", m_axis_tuser, want.status);
          if (m_axis_tlast != want.last_out)
            flag_mismatch("last_out", m_axis_tlast, want.last_out);
        end
      end
    end
  end

  // Sink side: bursts of ready with random stalls, some long
  initial begin
    int run;
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      @(posedge clk_i);
      m_axis_tready <= 1'b1;
      repeat (run - 1) @(posedge clk_i);
      stall = gap_len();
      if (stall > 0) begin
        @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk_i);
      end
    end
  end

  // Source side: directed table, then random names
  initial begin
    int gap;
    int burst_left;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    clear_name();
    for (int i = 0; i < DirRows; i++) name_stream.push_back(DirTable[i]);
    while (name_stream.size() < ItemGoal) random_name();

    @(posedge rst_ni);
    @(posedge clk_i);
    burst_left = 0;
    foreach (name_stream[i]) begin
      // stretches without any idling between runs with random gaps
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = gap_len();
        if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 60);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= name_stream[i].ch;
      s_axis_tlast  <= name_stream[i].fin;
      do @(posedge clk_i); while (!s_axis_tready);
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    // drain every outstanding beat, then watch for strays
    @(posedge clk_i);
    while (entry_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("sent %0d name bytes: %0d valid names, %0d rejected names",
             chars_in, names_valid, names_bad);
    $display("checked %0d entry beats in %0d cycles", beats_out, cycles);
    if (mismatches == 0 && entry_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
